/* design/mi3_pkg.sv */
// Shared constants for the 3x3 matrix inverse pipeline.
// No dependencies; used by the cofactor and determinant stages, the top level and the checker.
package mi3_pkg;

  // Number of matrix elements and of cofactors, in column-major order.
  localparam int N_ELEM = 9;

  // Number of terms in the row-0 expansion of the determinant.
  localparam int N_DET = 3;

  // Pipeline stages that do not depend on the element width.
  // These are two cofactor stages, three determinant stages, two numerator
  // stages and one output stage, plus the one quotient stage beyond the
  // element width (the divider decides ELEMENT_WIDTH + 1 quotient bits).
  localparam int PIPE_FIXED = 9;

  // Each cofactor is e[A]*e[B] - e[C]*e[D], indexed column-major (col*3+row).
  localparam int COF_A [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int COF_B [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int COF_C [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int COF_D [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  // Row-0 elements of the matrix, which weight cofactors 0..2 in the determinant.
  localparam int ROW0 [N_DET] = '{0, 3, 6};

endpackage

/* design/mi3_cof.sv */
// Cofactor stages: the eighteen element products, then the nine differences.
// Depends on mi3_pkg for the cofactor index tables.
module mi3_cof #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [W-1:0]  e_i    [mi3_pkg::N_ELEM],
  output logic                 valid_o,
  output logic signed [2*W:0]  cof_o  [mi3_pkg::N_ELEM],
  output logic signed [W-1:0]  row0_o [mi3_pkg::N_DET]
);

  localparam int CW = 2 * W + 1;

  logic                 v1_r, v2_r;
  logic signed [2*W-1:0] pa_r   [mi3_pkg::N_ELEM];
  logic signed [2*W-1:0] pb_r   [mi3_pkg::N_ELEM];
  logic signed [CW-1:0]  cof_r  [mi3_pkg::N_ELEM];
  logic signed [W-1:0]   row1_r [mi3_pkg::N_DET];
  logic signed [W-1:0]   row2_r [mi3_pkg::N_DET];

  // Valid bits follow the data through both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // Stage 1 forms the products, stage 2 the exact differences.
  always_ff @(posedge clk) begin
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      pa_r[k]  <= e_i[mi3_pkg::COF_A[k]] * e_i[mi3_pkg::COF_B[k]];
      pb_r[k]  <= e_i[mi3_pkg::COF_C[k]] * e_i[mi3_pkg::COF_D[k]];
      cof_r[k] <= CW'(pa_r[k]) - CW'(pb_r[k]);
    end
    for (int j = 0; j < mi3_pkg::N_DET; j++) begin
      row1_r[j] <= e_i[mi3_pkg::ROW0[j]];
      row2_r[j] <= row1_r[j];
    end
  end

  assign valid_o = v2_r;
  assign cof_o   = cof_r;
  assign row0_o  = row2_r;

endmodule

/* design/mi3_det.sv */
// Determinant stages: split products, their sum, then magnitude and sign.
// Depends on mi3_pkg; delays the cofactors alongside the determinant.
module mi3_det #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  logic signed [2*W:0]    cof_i  [mi3_pkg::N_ELEM],
  input  logic signed [W-1:0]    row0_i [mi3_pkg::N_DET],
  output logic                   valid_o,
  output logic signed [2*W:0]    cof_o  [mi3_pkg::N_ELEM],
  output logic [3*W+2:0]         dmag_o,
  output logic                   dneg_o,
  output logic                   dzero_o
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic                 v3_r, v4_r, v5_r;
  logic signed [CW-1:0] lo_r [mi3_pkg::N_DET];
  logic signed [CW-1:0] hi_r [mi3_pkg::N_DET];
  logic signed [DW-1:0] det_nxt;
  logic signed [DW-1:0] det_r;
  logic [DW-1:0]        dmag_r;
  logic                 dneg_r, dzero_r;
  logic signed [CW-1:0] c3_r [mi3_pkg::N_ELEM];
  logic signed [CW-1:0] c4_r [mi3_pkg::N_ELEM];
  logic signed [CW-1:0] c5_r [mi3_pkg::N_ELEM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= valid_i;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Sum of the three split products, the high half weighted by 2^W.
  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < mi3_pkg::N_DET; j++) begin
      det_nxt = det_nxt + (DW'(hi_r[j]) <<< W) + DW'(lo_r[j]);
    end
  end

  // Cofactors 0..2 are each cut into unsigned low and signed high halves.
  always_ff @(posedge clk) begin
    for (int j = 0; j < mi3_pkg::N_DET; j++) begin
      lo_r[j] <= row0_i[j] * signed'({1'b0, cof_i[j][W-1:0]});
      hi_r[j] <= row0_i[j] * signed'(cof_i[j][CW-1:W]);
    end
    det_r   <= det_nxt;
    dmag_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    dneg_r  <= det_r[DW-1];
    dzero_r <= (det_r == '0);
    c3_r    <= cof_i;
    c4_r    <= c3_r;
    c5_r    <= c4_r;
  end

  assign valid_o = v5_r;
  assign cof_o   = c5_r;
  assign dmag_o  = dmag_r;
  assign dneg_o  = dneg_r;
  assign dzero_o = dzero_r;

endmodule

/* design/mi3_div.sv */
// One divider lane: cofactor scaled by 2^(2F) over the determinant,
// one quotient bit per stage, then sign and saturation. No package use.
module mi3_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic signed [2*W:0] cof_i,
  input  logic [3*W+2:0]      dmag_i,
  input  logic                dneg_i,
  input  logic                dzero_i,
  output logic                valid_o,
  output logic signed [W-1:0] q_o,
  output logic                sing_o
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * F;
  localparam int RW = DW + 1;
  localparam int QW = W + 1;

  logic            v1_r;
  logic [CW-1:0]   nmag_r;
  logic            neg1_r, z1_r;
  logic [DW-1:0]   d1_r;
  logic [NW-1:0]   num;

  // Stage s holds the state before quotient bit QW-1-s is decided.
  logic [RW-1:0]   r_r   [QW+1];
  logic [QW-1:0]   nlo_r [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic [DW-1:0]   d_r   [QW+1];
  logic            neg_r [QW+1];
  logic            big_r [QW+1];
  logic            z_r   [QW+1];
  logic            v_r   [QW+1];

  logic [RW-1:0]   r2    [QW];
  logic            ge    [QW];

  logic [QW-1:0]   lim;
  logic [QW-1:0]   res_nxt;
  logic [W-1:0]    res_r;
  logic            sing_r, vo_r;

  // Valid bits through every stage of the lane.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vo_r <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      v1_r   <= valid_i;
      v_r[0] <= v1_r;
      for (int s = 0; s < QW; s++) begin
        v_r[s+1] <= v_r[s];
      end
      vo_r <= v_r[QW];
    end
  end

  assign num = NW'(nmag_r) << (2 * F);

  // Restoring step: shift in one numerator bit, subtract where it fits.
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      r2[s] = {r_r[s][RW-2:0], nlo_r[s][QW-1]};
      ge[s] = (r2[s] >= RW'(d_r[s]));
    end
  end

  // Saturate the magnitude by the quotient's sign; a zero determinant gives zero.
  always_comb begin
    lim = QW'(1) << (W - 1);
    priority if (z_r[QW]) begin
      res_nxt = '0;
    end else if (neg_r[QW]) begin
      res_nxt = (big_r[QW] || (q_r[QW] > lim)) ? -lim : -q_r[QW];
    end else begin
      res_nxt = (big_r[QW] || (q_r[QW] > lim - QW'(1))) ? lim - QW'(1) : q_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    // Magnitude of the numerator and sign of the quotient.
    nmag_r <= cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
    neg1_r <= cof_i[CW-1] ^ dneg_i;
    z1_r   <= dzero_i;
    d1_r   <= dmag_i;
    // The quotient overflows QW bits exactly when the top numerator bits reach d.
    r_r[0]   <= RW'(num[NW-1:QW]);
    nlo_r[0] <= num[QW-1:0];
    q_r[0]   <= '0;
    d_r[0]   <= d1_r;
    neg_r[0] <= neg1_r;
    big_r[0] <= (RW'(num[NW-1:QW]) >= RW'(d1_r));
    z_r[0]   <= z1_r;
    for (int s = 0; s < QW; s++) begin
      r_r[s+1]   <= ge[s] ? r2[s] - RW'(d_r[s]) : r2[s];
      nlo_r[s+1] <= nlo_r[s] << 1;
      q_r[s+1]   <= {q_r[s][QW-2:0], ge[s]};
      d_r[s+1]   <= d_r[s];
      neg_r[s+1] <= neg_r[s];
      big_r[s+1] <= big_r[s];
      z_r[s+1]   <= z_r[s];
    end
    res_r  <= res_nxt[W-1:0];
    sing_r <= z_r[QW];
  end

  assign valid_o = vo_r;
  assign q_o     = signed'(res_r);
  assign sing_o  = sing_r;

endmodule

/* design/matrix_inverse_3x3.sv */
// Top level of the 3x3 matrix inverse by the adjugate method.
// Depends on mi3_pkg, mi3_cof, mi3_det and mi3_div.
//
// The block takes one matrix request per clock while busy is low and
// returns its inverse, one result per request, in order. The pipeline depth
// is set by the divider lanes, which decide one quotient bit per pipeline
// stage (ELEMENT_WIDTH + 1 stages), behind two cofactor stages and three
// determinant stages. busy is high only while reset is applied and in the
// cycle after; otherwise start is taken at every clock. Each result appears
// for exactly one cycle with out_valid high, and must be taken then. A zero
// determinant sets out_singular and zeroes every inverse element; other
// quotients are truncated toward zero and saturated to the element format.
module matrix_inverse_3x3 #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r0_c0,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r1_c0,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r2_c0,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r0_c1,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r1_c1,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r2_c1,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r0_c2,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r1_c2,
  input  logic signed [ELEMENT_WIDTH-1:0] in_m_r2_c2,
  output logic                            out_valid,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r0_c0,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r1_c0,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r2_c0,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r0_c1,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r1_c1,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r2_c1,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r0_c2,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r1_c2,
  output logic signed [ELEMENT_WIDTH-1:0] out_inv_r2_c2,
  output logic                            out_singular
);

  localparam int W  = ELEMENT_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic                 busy_r;
  logic                 in_fire;
  logic signed [W-1:0]  elem   [mi3_pkg::N_ELEM];
  logic                 cof_v;
  logic signed [CW-1:0] cof    [mi3_pkg::N_ELEM];
  logic signed [W-1:0]  row0   [mi3_pkg::N_DET];
  logic                 det_v;
  logic signed [CW-1:0] cof_d  [mi3_pkg::N_ELEM];
  logic [DW-1:0]        dmag;
  logic                 dneg, dzero;
  logic [mi3_pkg::N_ELEM-1:0] lane_v;
  logic [mi3_pkg::N_ELEM-1:0] lane_s;
  logic signed [W-1:0]  lane_q [mi3_pkg::N_ELEM];

  // The pipeline never stalls, so busy only covers reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_fire = start & ~busy_r;

  // Elements in column-major order.
  assign elem[0] = in_m_r0_c0;
  assign elem[1] = in_m_r1_c0;
  assign elem[2] = in_m_r2_c0;
  assign elem[3] = in_m_r0_c1;
  assign elem[4] = in_m_r1_c1;
  assign elem[5] = in_m_r2_c1;
  assign elem[6] = in_m_r0_c2;
  assign elem[7] = in_m_r1_c2;
  assign elem[8] = in_m_r2_c2;

  mi3_cof #(.W(W)) u_cof (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_fire),
    .e_i     (elem),
    .valid_o (cof_v),
    .cof_o   (cof),
    .row0_o  (row0)
  );

  mi3_det #(.W(W)) u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (cof_v),
    .cof_i   (cof),
    .row0_i  (row0),
    .valid_o (det_v),
    .cof_o   (cof_d),
    .dmag_o  (dmag),
    .dneg_o  (dneg),
    .dzero_o (dzero)
  );

  // One divider lane per inverse element.
  for (genvar k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_lane
    mi3_div #(.W(W), .F(FRACTION_BITS)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (det_v),
      .cof_i   (cof_d[k]),
      .dmag_i  (dmag),
      .dneg_i  (dneg),
      .dzero_i (dzero),
      .valid_o (lane_v[k]),
      .q_o     (lane_q[k]),
      .sing_o  (lane_s[k])
    );
  end

  // All lanes run in lockstep and carry the same valid and singular bits.
  assign out_valid     = &lane_v;
  assign out_singular  = |lane_s;
  assign out_inv_r0_c0 = lane_q[0];
  assign out_inv_r1_c0 = lane_q[1];
  assign out_inv_r2_c0 = lane_q[2];
  assign out_inv_r0_c1 = lane_q[3];
  assign out_inv_r1_c1 = lane_q[4];
  assign out_inv_r2_c1 = lane_q[5];
  assign out_inv_r0_c2 = lane_q[6];
  assign out_inv_r1_c2 = lane_q[7];
  assign out_inv_r2_c2 = lane_q[8];

endmodule

/* design/mi3_checker.sv */
// Port-level checks for matrix_inverse_3x3, bound to the top level.
// Depends on mi3_pkg for the fixed part of the pipeline latency.
module mi3_checker #(
  parameter int ELEMENT_WIDTH = 32
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic                     out_singular,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r0_c0,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r1_c0,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r2_c0,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r0_c1,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r1_c1,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r2_c1,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r0_c2,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r1_c2,
  input logic [ELEMENT_WIDTH-1:0] out_inv_r2_c2
);

  localparam int LAT = ELEMENT_WIDTH + mi3_pkg::PIPE_FIXED;

  // Once out of reset the block keeps taking requests.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  // Every result traces back to a request a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // A singular matrix gives an all-zero inverse.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |->
      (out_inv_r0_c0 == '0) && (out_inv_r1_c0 == '0) && (out_inv_r2_c0 == '0) &&
      (out_inv_r0_c1 == '0) && (out_inv_r1_c1 == '0) && (out_inv_r2_c1 == '0) &&
      (out_inv_r0_c2 == '0) && (out_inv_r1_c2 == '0) && (out_inv_r2_c2 == '0))
    else $error("singular result with nonzero elements");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mi3_checker (.*);
